// ----- hw/rtl/wnms_pkg.sv -----
// ----------------------------------------------------------------------------
// wnms_pkg
// Shared types and constants of the window non-maximum suppression block.
// ----------------------------------------------------------------------------
package wnms_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int SIZE_BITS     = 11;
    localparam int COORD_BITS    = 10;
    localparam int THR_BITS      = 16;
    localparam int HALF_BITS     = 2;
    localparam int COUNT_LIMIT   = 1024;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_SCORE_THRESHOLD = 2'd2,
        CFG_WINDOW_HALF     = 2'd3
    } t_cfg_idx;

    typedef logic [SIZE_BITS-1:0]         t_size;
    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic signed [THR_BITS-1:0]   t_thr;
    typedef logic [HALF_BITS-1:0]         t_half;

    localparam t_size RST_FRAME_WIDTH     = 11'd640;
    localparam t_size RST_FRAME_HEIGHT    = 11'd480;
    localparam t_thr  RST_SCORE_THRESHOLD = 16'sd410;
    localparam t_half RST_WINDOW_HALF     = 2'd3;

endpackage

// ----- hw/rtl/wnms_if.sv -----
// ----------------------------------------------------------------------------
// wnms_if
// Valid/ready channels for score pixels in and suppressed points out.
// ----------------------------------------------------------------------------
interface wnms_px_if #(
    parameter int SCORE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [SCORE_BITS-1:0] score;
    logic                         frame_start;

    modport source (output valid, output score, output frame_start, input ready);
    modport sink   (input valid, input score, input frame_start, output ready);
endinterface

interface wnms_pt_if;
    logic                 valid;
    logic                 ready;
    wnms_pkg::t_coord     point_x;
    wnms_pkg::t_coord     point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ----- hw/rtl/window_non_maximum_suppression.sv -----
// ----------------------------------------------------------------------------
// window_non_maximum_suppression
// Streaming square-window non-maximum suppression over a raster of scores.
// ----------------------------------------------------------------------------
// The block takes one score pixel per clock while not held off. A point is
// offered on the output once its window is complete, from the memory stage
// registers through a one-entry output register. The rate is set by the line
// memory, which holds one column of MAX_WINDOW-1 earlier rows per word and is
// read and written once per pixel; a request is held off only while the
// output register is full and not taken.
// A one-pixel-wide frame reuses a word on consecutive pixels, which the
// write data bypass covers. The line memory needs no clearing after reset.
module window_non_maximum_suppression #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7,
    parameter int SCORE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wnms_px_if.sink                            i_px,
    wnms_pt_if.source                          o_pt,
    input  logic                               i_cfg_we,
    input  logic [wnms_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wnms_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int LINES = MAX_WINDOW - 1;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WINDOW);
    localparam int KMAX  = (MAX_WINDOW - 1) / 2;
    localparam int WLIM  = (MAX_WIDTH < wnms_pkg::COUNT_LIMIT) ? MAX_WIDTH
                                                               : wnms_pkg::COUNT_LIMIT;
    localparam int CB    = wnms_pkg::COORD_BITS;
    localparam int SZB   = wnms_pkg::SIZE_BITS;

    typedef logic signed [SCORE_BITS-1:0] t_score;
    typedef t_score [LINES-1:0]           t_col;
    typedef logic [AW-1:0]                t_addr;

    // Configuration.
    wnms_pkg::t_size r_width;
    wnms_pkg::t_size r_height;
    wnms_pkg::t_thr  r_thr;
    wnms_pkg::t_half r_half;

    // Position counters.
    wnms_pkg::t_coord r_col;
    wnms_pkg::t_coord r_row;
    logic             r_done;

    // Memory stage.
    t_col             mem [MAX_WIDTH];
    t_col             r_rdata;
    t_col             r_wlast;
    logic             r_s1_valid;
    logic             r_s1_fwd;
    logic             r_s1_elig;
    t_addr            r_s1_addr;
    t_score           r_s1_px;
    wnms_pkg::t_coord r_s1_x;
    wnms_pkg::t_coord r_s1_y;
    wnms_pkg::t_half  r_s1_k;

    t_score           r_win [MAX_WINDOW][MAX_WINDOW];

    // Output register.
    logic             r_o_valid;
    wnms_pkg::t_coord r_o_x;
    wnms_pkg::t_coord r_o_y;

    wnms_pkg::t_size  w_eff;
    wnms_pkg::t_size  h_eff;
    wnms_pkg::t_half  k_eff;
    logic [2:0]       d_eff;
    logic             fs;
    logic             done0;
    wnms_pkg::t_coord col0;
    wnms_pkg::t_coord row0;
    wnms_pkg::t_size  col_p1;
    wnms_pkg::t_size  row_p1;
    t_addr            addr0;
    logic             accept;
    logic             take;
    logic             elig0;
    logic             s1_adv;

    t_col             s1_src;
    t_col             s1_wdata;
    t_score           new_win [MAX_WINDOW][MAX_WINDOW];
    logic [WB-1:0]    mid;
    logic [WB-1:0]    lo;
    t_score           center;
    logic             beaten;
    logic             found;

    always_comb begin
        if (r_width == '0) begin
            w_eff = SZB'(1);
        end else if (r_width > SZB'(WLIM)) begin
            w_eff = SZB'(WLIM);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = SZB'(1);
        end else if (r_height > SZB'(wnms_pkg::COUNT_LIMIT)) begin
            h_eff = SZB'(wnms_pkg::COUNT_LIMIT);
        end else begin
            h_eff = r_height;
        end
        if (int'(r_half) > KMAX) begin
            k_eff = wnms_pkg::HALF_BITS'(KMAX);
        end else begin
            k_eff = r_half;
        end
        d_eff = {k_eff, 1'b0};
    end

    always_comb begin
        fs     = i_px.frame_start;
        done0  = r_done && !fs;
        col0   = fs ? '0 : r_col;
        row0   = fs ? '0 : r_row;
        col_p1 = {1'b0, col0} + SZB'(1);
        row_p1 = {1'b0, row0} + SZB'(1);
        addr0  = AW'(col0);
        elig0  = ({1'b0, col0} < w_eff) && ({1'b0, row0} < h_eff)
              && (col0 >= CB'(d_eff)) && (row0 >= CB'(d_eff));
    end

    assign s1_adv      = !r_o_valid || o_pt.ready;
    assign i_px.ready  = !r_s1_valid || s1_adv;
    assign accept      = i_px.valid && i_px.ready;
    assign take        = accept && !done0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= wnms_pkg::RST_FRAME_WIDTH;
            r_height   <= wnms_pkg::RST_FRAME_HEIGHT;
            r_thr      <= wnms_pkg::RST_SCORE_THRESHOLD;
            r_half     <= wnms_pkg::RST_WINDOW_HALF;
            r_col      <= '0;
            r_row      <= '0;
            r_done     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (wnms_pkg::t_cfg_idx'(i_cfg_idx))
                    wnms_pkg::CFG_FRAME_WIDTH:     r_width  <= SZB'(i_cfg_data);
                    wnms_pkg::CFG_FRAME_HEIGHT:    r_height <= SZB'(i_cfg_data);
                    wnms_pkg::CFG_SCORE_THRESHOLD: r_thr    <= i_cfg_data;
                    wnms_pkg::CFG_WINDOW_HALF:     r_half   <= wnms_pkg::HALF_BITS'(i_cfg_data);
                endcase
            end
            if (take) begin
                r_done <= 1'b0;
                if (col_p1 >= w_eff) begin
                    r_col <= '0;
                    if (row_p1 >= h_eff) begin
                        r_row  <= '0;
                        r_done <= 1'b1;
                    end else begin
                        r_row <= CB'(row_p1);
                    end
                end else begin
                    r_col <= CB'(col_p1);
                    r_row <= row0;
                end
            end
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= r_s1_valid && found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rdata   <= mem[addr0];
            r_s1_fwd  <= r_s1_valid && (r_s1_addr == addr0);
            r_s1_addr <= addr0;
            r_s1_px   <= i_px.score;
            r_s1_elig <= elig0;
            r_s1_x    <= col0 - CB'(k_eff);
            r_s1_y    <= row0 - CB'(k_eff);
            r_s1_k    <= k_eff;
        end
        if (r_s1_valid && s1_adv) begin
            mem[r_s1_addr] <= s1_wdata;
            r_wlast        <= s1_wdata;
            r_win          <= new_win;
        end
        if (s1_adv && found) begin
            r_o_x <= r_s1_x;
            r_o_y <= r_s1_y;
        end
    end

    always_comb begin
        s1_src      = r_s1_fwd ? r_wlast : r_rdata;
        s1_wdata[0] = r_s1_px;
        for (int j = 1; j < LINES; j++) begin
            s1_wdata[j] = s1_src[j-1];
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
            for (int j = 0; j < MAX_WINDOW - 1; j++) begin
                new_win[i][j] = r_win[i][j+1];
            end
            if (i < LINES) begin
                new_win[i][MAX_WINDOW-1] = s1_src[LINES-1-i];
            end else begin
                new_win[i][MAX_WINDOW-1] = r_s1_px;
            end
        end
    end

    always_comb begin
        mid    = WB'(MAX_WINDOW - 1) - WB'(r_s1_k);
        lo     = WB'(MAX_WINDOW - 1) - WB'({r_s1_k, 1'b0});
        center = new_win[mid][mid];
        beaten = 1'b0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            for (int j = 0; j < MAX_WINDOW; j++) begin
                if ((i >= int'(lo)) && (j >= int'(lo)) && (new_win[i][j] > center)) begin
                    beaten = 1'b1;
                end
            end
        end
        found = r_s1_elig && (center >= r_thr) && !beaten;
    end

    assign o_pt.valid   = r_o_valid;
    assign o_pt.point_x = r_o_x;
    assign o_pt.point_y = r_o_y;

endmodule

// ----- hw/rtl/wnms_checker.sv -----
// ----------------------------------------------------------------------------
// wnms_checker
// Port-level checks of the window non-maximum suppression block.
// ----------------------------------------------------------------------------
module wnms_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_px_valid,
    input logic             i_px_ready,
    input logic             i_pt_valid,
    input logic             i_pt_ready,
    input wnms_pkg::t_coord i_point_x,
    input wnms_pkg::t_coord i_point_y
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pt_valid)
        else $error("Result valid after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt_valid && !i_pt_ready |=>
            i_pt_valid && $stable(i_point_x) && $stable(i_point_y))
        else $error("Stalled result changed.");

    a_out_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_pt_valid) |-> $past(i_px_valid && i_px_ready, 2))
        else $error("New result without a request two cycles earlier.");

    a_stall_only_on_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_px_ready |-> i_pt_valid && !i_pt_ready)
        else $error("Input held off while the output is free.");

endmodule

bind window_non_maximum_suppression wnms_checker u_wnms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_px_valid (i_px.valid),
    .i_px_ready (i_px.ready),
    .i_pt_valid (o_pt.valid),
    .i_pt_ready (o_pt.ready),
    .i_point_x  (o_pt.point_x),
    .i_point_y  (o_pt.point_y)
);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the window non-maximum suppression block. A
// scoreboard class keeps its own line stores, window and position counters,
// predicts every reported point from the accepted score requests, and
// compares each point that leaves the block with the oldest prediction.
// Both channels idle at random, and the point sink holds off once for a long
// stretch so that the block backs up into the score channel.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        wnms_pkg::t_coord x;
        wnms_pkg::t_coord y;
    } t_point;

    class t_nms_tracker;
        logic signed [15:0] rows_mem [6][1024];
        logic signed [15:0] win [7][7];
        int unsigned        col;
        int unsigned        row;
        bit                 done;
        wnms_pkg::t_size    width_cfg;
        wnms_pkg::t_size    height_cfg;
        wnms_pkg::t_thr     thr_cfg;
        wnms_pkg::t_half    half_cfg;
        t_point             pending[$];
        int                 errors;

        function new();
            foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            col        = 0;
            row        = 0;
            done       = 1'b0;
            width_cfg  = wnms_pkg::RST_FRAME_WIDTH;
            height_cfg = wnms_pkg::RST_FRAME_HEIGHT;
            thr_cfg    = wnms_pkg::RST_SCORE_THRESHOLD;
            half_cfg   = wnms_pkg::RST_WINDOW_HALF;
            errors     = 0;
        endfunction

        function int unsigned eff_size(input wnms_pkg::t_size v);
            if (v == 0) begin
                return 1;
            end
            return (v > wnms_pkg::COUNT_LIMIT) ? wnms_pkg::COUNT_LIMIT : v;
        endfunction

        function void set_reg(input wnms_pkg::t_cfg_idx idx, input logic [15:0] data);
            case (idx)
                wnms_pkg::CFG_FRAME_WIDTH: begin
                    width_cfg = data[wnms_pkg::SIZE_BITS-1:0];
                end
                wnms_pkg::CFG_FRAME_HEIGHT: begin
                    height_cfg = data[wnms_pkg::SIZE_BITS-1:0];
                end
                wnms_pkg::CFG_SCORE_THRESHOLD: begin
                    thr_cfg = data;
                end
                wnms_pkg::CFG_WINDOW_HALF: begin
                    half_cfg = data[wnms_pkg::HALF_BITS-1:0];
                end
            endcase
        endfunction

        function void take_pixel(input logic signed [15:0] px, input logic fs);
            int unsigned        w;
            int unsigned        h;
            int unsigned        c;
            int unsigned        r;
            int unsigned        k;
            int unsigned        d;
            int                 i;
            int                 j;
            logic signed [15:0] center;
            bit                 beaten;
            t_point             pt;

            if (fs) begin
                col  = 0;
                row  = 0;
                done = 1'b0;
            end
            if (done) begin
                return;
            end
            w = eff_size(width_cfg);
            h = eff_size(height_cfg);
            c = col % 1024;
            r = row;

            for (i = 0; i < 7; i++) begin
                for (j = 0; j < 6; j++) begin
                    win[i][j] = win[i][j+1];
                end
                win[i][6] = (i < 6) ? rows_mem[5-i][c] : px;
            end
            for (j = 5; j > 0; j--) begin
                rows_mem[j][c] = rows_mem[j-1][c];
            end
            rows_mem[0][c] = px;

            k = half_cfg;
            d = 2 * k;
            if (c < w && r < h && c >= d && r >= d) begin
                center = win[6-k][6-k];
                if (center >= thr_cfg) begin
                    beaten = 1'b0;
                    for (i = 6 - d; i < 7; i++) begin
                        for (j = 6 - d; j < 7; j++) begin
                            if (win[i][j] > center) begin
                                beaten = 1'b1;
                            end
                        end
                    end
                    if (!beaten) begin
                        pt.x = wnms_pkg::t_coord'(c - k);
                        pt.y = wnms_pkg::t_coord'(r - k);
                        pending = {pending, pt};
                    end
                end
            end

            if (c + 1 >= w) begin
                col = 0;
                if (r + 1 >= h) begin
                    row  = 0;
                    done = 1'b1;
                end else begin
                    row = (r + 1) & 10'h3FF;
                end
            end else begin
                col = (c + 1) & 10'h3FF;
            end
        endfunction

        function void match_point(input wnms_pkg::t_coord x, input wnms_pkg::t_coord y);
            t_point want;

            if (pending.size() == 0) begin
                $display("%0t: point (%0d,%0d) reported with none expected", $time, x, y);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (x !== want.x) begin
                $display("%0t: point_x expected %0d, actual %0d", $time, want.x, x);
                errors++;
            end
            if (y !== want.y) begin
                $display("%0t: point_y expected %0d, actual %0d", $time, want.y, y);
                errors++;
            end
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [wnms_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [wnms_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    bit no_gaps  = 1'b0;
    bit hold_off = 1'b0;

    t_nms_tracker tracker;

    logic signed [15:0] probe_frame [16] = '{
        16'sh8000, 16'sd5, 16'sd5, 16'sh7FFF,
        16'sh8000, 16'sd5, 16'sd5, 16'sd0,
        16'sd0,    16'sd5, 16'sh8000, 16'sh7FFF,
        16'sd5,    16'sd5, 16'sd5, 16'sh8000
    };

    wnms_px_if #(.SCORE_BITS(16)) px_if ();
    wnms_pt_if pt_if ();

    window_non_maximum_suppression #(
        .MAX_WIDTH  (1024),
        .MAX_WINDOW (7),
        .SCORE_BITS (16)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_px       (px_if.sink),
        .o_pt       (pt_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic signed [15:0] draw_score();
        case ($urandom_range(9, 0))
            0: begin
                return 16'sh7FFF;
            end
            1: begin
                return 16'sh8000;
            end
            2, 3, 4, 5: begin
                return 16'($urandom_range(7, 0));
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    task automatic send_pixel(input logic signed [15:0] s, input logic fs);
        int gap;

        gap = no_gaps ? 0 : $urandom_range(15, 0);
        if (gap > 0) begin
            px_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        px_if.valid       <= 1'b1;
        px_if.score       <= s;
        px_if.frame_start <= fs;
        do @(posedge i_clk); while (!px_if.ready);
        tracker.take_pixel(s, fs);
    endtask

    task automatic send_frame(input int npix, input bit rough);
        int n;
        int extra;
        int i;

        n     = npix;
        extra = 0;
        if (rough && $urandom_range(7, 0) == 0) begin
            n = $urandom_range(npix, 1);
        end else if (rough && $urandom_range(3, 0) == 0) begin
            extra = $urandom_range(3, 1);
        end
        for (i = 0; i < n + extra; i++) begin
            send_pixel(draw_score(), i == 0);
        end
    endtask

    task automatic write_reg(input wnms_pkg::t_cfg_idx idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic configure(input wnms_pkg::t_size w, input wnms_pkg::t_size h,
                             input wnms_pkg::t_thr thr, input wnms_pkg::t_half k);
        write_reg(wnms_pkg::CFG_FRAME_WIDTH, 16'(w));
        write_reg(wnms_pkg::CFG_FRAME_HEIGHT, 16'(h));
        write_reg(wnms_pkg::CFG_SCORE_THRESHOLD, thr);
        write_reg(wnms_pkg::CFG_WINDOW_HALF, 16'(k));
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        px_if.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin : point_sink
        int stall;

        pt_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                pt_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            stall = no_gaps ? 0 : $urandom_range(15, 0);
            if (stall > 0) begin
                pt_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pt_if.ready <= 1'b1;
            do @(posedge i_clk); while (!pt_if.valid);
            tracker.match_point(pt_if.point_x, pt_if.point_y);
        end
    end

    initial begin : run_limit
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : score_source
        int i;

        tracker = new();
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= wnms_pkg::CFG_FRAME_WIDTH;
        i_cfg_data        <= '0;
        px_if.valid       <= 1'b0;
        px_if.score       <= '0;
        px_if.frame_start <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A frame is restarted partway, then run to its end, then fed one
        // more request that must be ignored.
        configure(11'd4, 11'd4, 16'sh8000, 2'd1);
        for (i = 0; i < 5; i++) begin
            send_pixel(probe_frame[i], i == 0);
        end
        for (i = 0; i < 16; i++) begin
            send_pixel(probe_frame[i], i == 0);
        end
        send_pixel(16'sh7FFF, 1'b0);
        settle();

        // Zero sizes act as a single pixel frame at the top threshold.
        configure(11'd0, 11'd0, 16'sh7FFF, 2'd0);
        send_pixel(16'sh7FFF, 1'b1);
        send_pixel(16'sh7FFE, 1'b1);
        send_pixel(16'sh7FFF, 1'b0);
        settle();

        configure(11'd9, 11'd9, 16'sd2, 2'd3);
        repeat (2) send_frame(81, 1'b1);
        settle();

        configure(11'd2047, 11'd1, wnms_pkg::t_thr'($urandom), 2'd0);
        send_frame(tracker.eff_size(11'd2047), 1'b0);
        settle();

        // Every request yields a point here, so the long sink hold-off
        // backs the block up into the score channel.
        no_gaps  = 1'b1;
        hold_off = 1'b1;
        configure(11'd1, 11'd2047, 16'sh8000, 2'd0);
        send_frame(80, 1'b0);
        settle();
        no_gaps = 1'b0;

        configure(11'd13, 11'd8, wnms_pkg::t_thr'($urandom_range(5, 0)), 2'd2);
        send_frame(104, 1'b1);
        settle();

        configure(11'd6, 11'd10, 16'sh7FFF, 2'd1);
        send_frame(60, 1'b1);
        settle();

        configure(11'd0, 11'd5, 16'sd0, 2'd0);
        repeat (4) send_frame(5, 1'b1);
        settle();

        no_gaps = 1'b1;
        configure(11'd11, 11'd11, 16'sh8000, 2'd3);
        send_frame(121, 1'b1);
        settle();
        no_gaps = 1'b0;

        configure(11'd7, 11'd7, 16'sd3, 2'd3);
        repeat (2) send_frame(49, 1'b1);
        settle();

        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/wnms_pkg.sv
hw/rtl/wnms_if.sv
hw/rtl/window_non_maximum_suppression.sv
hw/rtl/wnms_checker.sv
test/tb.sv
